// ===== src/hbk2ps2_pkg.sv =====
// shared types, scan code tables and lookup for the boot keyboard to set-1 converter
`default_nettype none

package hbk2ps2_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] USAGE_FIRST = 8'h04;
    localparam logic [7:0] USAGE_LAST  = 8'h65;
    localparam int         USAGE_NUM   = 98;
    localparam int         MOD_BITS    = 8;

    // set-1 code with extended flag in the top bit
    typedef struct packed {
        logic       ext;
        logic [7:0] code;
    } t_code;

    typedef struct packed {
        logic load;       // input transfer taken
        logic rw;         // read old history, write new report
        logic step_byte;  // emit prefix or code of the current step
        logic step_next;  // move to the next step
        logic flush;      // push the held byte out as the final one
    } t_cmd;

    typedef struct packed {
        logic is_report;    // offered item is a full report for a known device
        logic step_emit;    // current step produces a byte
        logic ext_pending;  // prefix still to go before the code
        logic last_step;
        logic hold_valid;
        logic out_free;
    } t_stat;

    // usages 0x04 .. 0x65, zero means no set-1 code
    localparam t_code USAGE_CODES [0:USAGE_NUM-1] = '{
        9'h01E, 9'h030, 9'h02E, 9'h020, 9'h012, 9'h021, 9'h022, 9'h023,
        9'h017, 9'h024, 9'h025, 9'h026, 9'h032, 9'h031, 9'h018, 9'h019,
        9'h010, 9'h013, 9'h01F, 9'h014, 9'h016, 9'h02F, 9'h011, 9'h02D,
        9'h015, 9'h02C, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006, 9'h007,
        9'h008, 9'h009, 9'h00A, 9'h00B, 9'h01C, 9'h001, 9'h00E, 9'h00F,
        9'h039, 9'h00C, 9'h00D, 9'h01A, 9'h01B, 9'h02B, 9'h000, 9'h027,
        9'h028, 9'h029, 9'h033, 9'h034, 9'h035, 9'h03A, 9'h03B, 9'h03C,
        9'h03D, 9'h03E, 9'h03F, 9'h040, 9'h041, 9'h042, 9'h043, 9'h044,
        9'h057, 9'h058, 9'h000, 9'h000, 9'h000, 9'h152, 9'h147, 9'h149,
        9'h153, 9'h14F, 9'h151, 9'h14D, 9'h14B, 9'h150, 9'h148, 9'h045,
        9'h135, 9'h037, 9'h04A, 9'h04E, 9'h11C, 9'h04F, 9'h050, 9'h051,
        9'h04B, 9'h04C, 9'h04D, 9'h047, 9'h048, 9'h049, 9'h052, 9'h053,
        9'h056, 9'h15D
    };

    // modifier bits 0 .. 7
    localparam t_code MOD_CODES [0:MOD_BITS-1] = '{
        9'h01D, 9'h02A, 9'h038, 9'h15B, 9'h11D, 9'h036, 9'h138, 9'h15C
    };

    function automatic t_code lookup_usage(input logic [7:0] usage);
        logic [7:0] idx;
        t_code      res;
        idx = usage - USAGE_FIRST;
        res = '0;
        if (usage >= USAGE_FIRST && usage <= USAGE_LAST) begin
            res = USAGE_CODES[idx[6:0]];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/hid_boot_kbd_to_ps2_set1_core.sv =====
// top level of the boot keyboard report to PS/2 set-1 byte converter
`default_nettype none

// Takes one boot keyboard report (or a history clear) per input transfer and
// sends the set-1 bytes it causes, one per output transfer, tlast on the final
// byte of a report. A clear, a short report or an unknown device is taken
// without leaving the idle state and sends nothing. A full report is latched,
// then its device history is fetched and replaced, then the sequencer walks the
// 8 + 2*KEY_SLOTS compare steps, sending an 0xE0 prefix before each extended
// code (up to 4 from the modifiers and one per key step), and at last releases
// the final byte. Output back-pressure stalls the step sequencer, which feeds
// the single held byte in front of the output register.
// History sits in a memory of NUM_DEVICES entries with one valid flag each,
// so it reads as zero straight after reset.
module hid_boot_kbd_to_ps2_set1_core #(
    parameter int NUM_DEVICES = 8,
    parameter int KEY_SLOTS   = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] device, [6:3] report_length, [14:7] modifiers,
    // [22:15] key_0 .. [62:55] key_5, [63] zero
    input  logic [63:0] i_s_axis_tdata,
    input  logic        i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] scan_byte
    output logic        o_m_axis_tlast    // last_byte
);
    import hbk2ps2_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    hbk2ps2_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_s_ready (o_s_axis_tready)
    );

    hbk2ps2_dp #(
        .NUM_DEVICES (NUM_DEVICES),
        .KEY_SLOTS   (KEY_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== src/hbk2ps2_ctrl.sv =====
// sequencer that walks a report through history fetch, steps and final byte
`default_nettype none

module hbk2ps2_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  hbk2ps2_pkg::t_stat  i_stat,
    output hbk2ps2_pkg::t_cmd   o_cmd,
    output logic                o_s_ready
);
    import hbk2ps2_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RW    = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       can_push;

    assign o_s_ready = (r_state == ST_IDLE);
    // a new byte displaces the held one only if the output register can take it
    assign can_push  = !i_stat.hold_valid || i_stat.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.is_report) begin
                        n_state = ST_RW;
                    end
                end
            end
            ST_RW: begin
                o_cmd.rw = 1'b1;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.step_emit) begin
                    if (can_push) begin
                        o_cmd.step_byte = 1'b1;
                        if (!i_stat.ext_pending) begin
                            o_cmd.step_next = 1'b1;
                            if (i_stat.last_step) begin
                                n_state = ST_FLUSH;
                            end
                        end
                    end
                end else begin
                    o_cmd.step_next = 1'b1;
                    if (i_stat.last_step) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_stat.hold_valid) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/hbk2ps2_dp.sv =====
// datapath: report latch, history memory, step decode, held byte and output register
`default_nettype none

module hbk2ps2_dp #(
    parameter int NUM_DEVICES = 8,
    parameter int KEY_SLOTS   = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [63:0]         i_s_tdata,
    input  logic                i_s_tuser,
    input  hbk2ps2_pkg::t_cmd   i_cmd,
    output hbk2ps2_pkg::t_stat  o_stat,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast
);
    import hbk2ps2_pkg::*;

    localparam int NSTEPS = MOD_BITS + 2 * KEY_SLOTS;
    localparam int STEP_W = $clog2(NSTEPS);
    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int DEV_AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int WORD_W = 8 + 8 * KEY_SLOTS;

    // input field positions in tdata
    logic [2:0] in_device;
    logic [3:0] in_length;
    logic [7:0] in_mods;
    logic       in_dev_ok;

    assign in_device = i_s_tdata[2:0];
    assign in_length = i_s_tdata[6:3];
    assign in_mods   = i_s_tdata[14:7];
    assign in_dev_ok = ({5'b0, in_device} < 8'(NUM_DEVICES));

    // latched report
    logic [2:0]  r_device;
    logic [7:0]  r_mods;
    logic [7:0]  r_keys [KEY_SLOTS];
    logic [DEV_AW-1:0] addr;

    assign addr = DEV_AW'(r_device);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_device <= in_device;
            r_mods   <= in_mods;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_keys[k] <= i_s_tdata[15 + 8 * k +: 8];
            end
        end
    end

    // history store, read-first so the old entry is fetched as the new one goes in
    logic [WORD_W-1:0] mem_hist [NUM_DEVICES];
    logic [WORD_W-1:0] r_rd_word;
    logic              r_rd_valid;
    logic [NUM_DEVICES-1:0] r_valid;
    logic [WORD_W-1:0] wr_word;

    always_comb begin
        wr_word[7:0] = r_mods;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            wr_word[8 + 8 * k +: 8] = r_keys[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rw) begin
            r_rd_word      <= mem_hist[addr];
            r_rd_valid     <= r_valid[addr];
            mem_hist[addr] <= wr_word;
        end
    end

    // an entry not marked valid reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.rw) begin
            r_valid[addr] <= 1'b1;
        end else if (i_cmd.load && i_s_tuser && in_dev_ok) begin
            r_valid[DEV_AW'(in_device)] <= 1'b0;
        end
    end

    logic [7:0] prev_mods;
    logic [7:0] prev_keys [KEY_SLOTS];

    always_comb begin
        prev_mods = r_rd_valid ? r_rd_word[7:0] : 8'h00;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            prev_keys[k] = r_rd_valid ? r_rd_word[8 + 8 * k +: 8] : 8'h00;
        end
    end

    // step decode: modifiers, then makes, then breaks
    logic [STEP_W-1:0] r_step;
    logic              r_pfx_done;
    logic              is_mod;
    logic              is_make;
    logic [STEP_W-1:0] step_off;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        sel_key;
    logic              hit;
    logic              cond;
    logic              brk;
    t_code             code;
    logic [7:0]        step_val;

    assign is_mod  = (r_step < STEP_W'(MOD_BITS));
    assign is_make = (r_step < STEP_W'(MOD_BITS + KEY_SLOTS));

    always_comb begin
        step_off = is_make ? STEP_W'(r_step - STEP_W'(MOD_BITS))
                           : STEP_W'(r_step - STEP_W'(MOD_BITS + KEY_SLOTS));
        slot     = step_off[SLOT_W-1:0];
        sel_key  = is_make ? r_keys[slot] : prev_keys[slot];
        hit      = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if ((is_make ? prev_keys[j] : r_keys[j]) == sel_key) begin
                hit = 1'b1;
            end
        end
        if (is_mod) begin
            cond = (r_mods[r_step[2:0]] != prev_mods[r_step[2:0]]);
            brk  = !r_mods[r_step[2:0]];
            code = MOD_CODES[r_step[2:0]];
        end else begin
            cond = (sel_key != 8'h00) && !hit;
            brk  = !is_make;
            code = lookup_usage(sel_key);
        end
        step_val = (code.ext && !r_pfx_done) ? PREFIX_BYTE
                                             : (code.code | (brk ? BREAK_BIT : 8'h00));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step     <= '0;
            r_pfx_done <= 1'b0;
        end else if (i_cmd.step_next) begin
            r_step     <= STEP_W'(r_step + 1'b1);
            r_pfx_done <= 1'b0;
        end else if (i_cmd.step_byte) begin
            r_pfx_done <= 1'b1;
        end
    end

    // held byte waits until the next one shows whether it is the final one
    logic       r_hold_valid;
    logic [7:0] r_hold_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.step_byte) begin
                r_hold_valid <= 1'b1;
                if (r_hold_valid) begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_byte) begin
            r_hold_byte <= step_val;
            if (r_hold_valid) begin
                r_out_byte <= r_hold_byte;
                r_out_last <= 1'b0;
            end
        end else if (i_cmd.flush) begin
            r_out_byte <= r_hold_byte;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    assign o_stat.is_report   = !i_s_tuser && in_length[3] && in_dev_ok;
    assign o_stat.step_emit   = cond && (code != '0);
    assign o_stat.ext_pending = code.ext && !r_pfx_done;
    assign o_stat.last_step   = (r_step == STEP_W'(NSTEPS - 1));
    assign o_stat.hold_valid  = r_hold_valid;
    assign o_stat.out_free    = out_free;

endmodule

`default_nettype wire

// ===== src/hbk2ps2_chk.sv =====
// port checker for the converter top level and its bind
`default_nettype none

module hbk2ps2_chk #(
    parameter int NUM_DEVICES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    input  logic        i_s_axis_tuser,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  o_m_axis_tdata,
    input  logic        o_m_axis_tlast
);

    logic in_xfer;
    logic full_rpt;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign full_rpt = !i_s_axis_tuser && i_s_axis_tdata[6]
                      && ({5'b0, i_s_axis_tdata[2:0]} < 8'(NUM_DEVICES));

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output payload changed while stalled");

    // clears, short reports and unknown devices finish in the accepting cycle
    a_quick_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !full_rpt |=> o_s_axis_tready)
        else $error("item without bytes held the input");

    // a full report always takes the history fetch cycle
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && full_rpt |=> !o_s_axis_tready)
        else $error("input ready straight after a full report");

endmodule

bind hid_boot_kbd_to_ps2_set1_core hbk2ps2_chk #(.NUM_DEVICES(NUM_DEVICES)) u_chk (.*);

`default_nettype wire
